### sv/cbvs_pkg.sv
// Package for the centred boxcar vector smoother: window size, field widths,
// pipeline depth and the reciprocal constants of the constant divider.
// No dependencies.
package cbvs_pkg;

  localparam int WINDOW = 20;

  localparam int SMP_W  = 32;
  localparam int TIME_W = 48;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SUM_W  = SMP_W + LOG_W;
  localparam int CENTER = WINDOW - 1 - WINDOW / 2;

  localparam int DIG_W  = 16;
  localparam int DIGITS = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int MAG_W  = DIGITS * DIG_W;
  localparam int REM_W  = LOG_W;
  localparam int PART_W = REM_W + DIG_W;
  localparam int RCP_SH = PART_W + REM_W;
  localparam int RCP_W  = PART_W + 2;
  localparam int PROD_W = PART_W + RCP_W;
  localparam longint unsigned RCP = ((64'd1 << RCP_SH) + WINDOW - 1) / WINDOW;
  localparam logic [RCP_W-1:0] RCP_V = RCP_W'(RCP);

  localparam int DIV_ST = 1 + 2 * DIGITS;

  typedef struct packed {
    logic signed [SMP_W-1:0] x;
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic             neg;
    logic [SMP_W-1:0] quo;
  } div_res_t;

endpackage

### sv/cbvs_div.sv
// Pipelined signed divide of a window sum by WINDOW, rounded toward zero.
// Long division one digit per two stages via reciprocal multiply; uses cbvs_pkg.
module cbvs_div import cbvs_pkg::*; (
  input  logic                    clk,
  input  logic [DIV_ST-1:0]       stage_en,
  input  logic signed [SUM_W-1:0] sum_in,
  output div_res_t                res
);

  logic [SUM_W-1:0]  sum_u;
  logic [SUM_W-1:0]  abs_c;
  logic [DIV_ST-1:0] neg_r;
  logic [MAG_W-1:0]  w_r [DIV_ST];
  logic [PART_W-1:0] part_c [DIGITS];
  logic [PART_W-1:0] part_r [DIGITS];
  logic [PROD_W-1:0] prod_r [DIGITS];
  logic [DIG_W-1:0]  q_c [DIGITS];
  logic [MAG_W-1:0]  w_c [DIGITS];
  logic [REM_W-1:0]  rem_c [DIGITS-1];
  logic [REM_W-1:0]  rem_r [DIGITS-1];

  localparam logic [MAG_W-1:0] DMASK = MAG_W'({DIG_W{1'b1}});

  assign sum_u = $unsigned(sum_in);
  assign abs_c = sum_in[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;

  for (genvar i = 0; i < DIGITS; i++) begin : g_dig
    localparam int SA = 1 + 2 * i;
    localparam int HI = MAG_W - 1 - i * DIG_W;
    localparam int LO = MAG_W - (i + 1) * DIG_W;
    if (i == 0) begin : g_first
      assign part_c[i] = PART_W'(w_r[SA-1][HI -: DIG_W]);
    end else begin : g_next
      assign part_c[i] = {rem_r[i-1], w_r[SA-1][HI -: DIG_W]};
    end
    assign q_c[i] = prod_r[i][RCP_SH +: DIG_W];
    assign w_c[i] = (w_r[SA] & ~(DMASK << LO)) | (MAG_W'(q_c[i]) << LO);
    if (i < DIGITS - 1) begin : g_rem
      assign rem_c[i] = REM_W'(part_r[i] - PART_W'(q_c[i]) * PART_W'(WINDOW));
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      neg_r[0] <= sum_in[SUM_W-1];
      w_r[0]   <= MAG_W'(abs_c);
    end
    for (int i = 0; i < DIGITS; i++) begin
      if (stage_en[1+2*i]) begin
        part_r[i]      <= part_c[i];
        prod_r[i]      <= part_c[i] * RCP_V;
        w_r[1+2*i]     <= w_r[2*i];
        neg_r[1+2*i]   <= neg_r[2*i];
      end
      if (stage_en[2+2*i]) begin
        w_r[2+2*i]     <= w_c[i];
        neg_r[2+2*i]   <= neg_r[1+2*i];
      end
    end
    for (int i = 0; i < DIGITS - 1; i++) begin
      if (stage_en[2+2*i]) begin
        rem_r[i] <= rem_c[i];
      end
    end
  end

  assign res.neg = neg_r[DIV_ST-1];
  assign res.quo = w_r[DIV_ST-1][SMP_W-1:0];

endmodule

### sv/centered_boxcar_vector_smoother.sv
// Centred boxcar moving average over timestamped three-axis velocity beats.
// Top level: shift-line window, running sums, three cbvs_div dividers; uses cbvs_pkg.
// Pipeline: running-sum register, then the divider's 7 stages, then the output register.
// Throughput: one beat per cycle while out_stall is low; a result per beat once WINDOW beats are held.
// Stages advance independently, so bubbles collapse under output stall.
// Reset (synchronous, rst_n low): window empty, sums zero, pipeline drained.
module centered_boxcar_vector_smoother import cbvs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TIME_W-1:0]        in_sample_time,
  input  logic signed [SMP_W-1:0]  in_sample_x,
  input  logic signed [SMP_W-1:0]  in_sample_y,
  input  logic signed [SMP_W-1:0]  in_sample_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [TIME_W-1:0]        out_center_time,
  output logic signed [SMP_W-1:0]  out_mean_x,
  output logic signed [SMP_W-1:0]  out_mean_y,
  output logic signed [SMP_W-1:0]  out_mean_z
);

  vec_t                    vel_r [WINDOW];
  logic [TIME_W-1:0]       t_r [CENTER+1];
  logic [CNT_W-1:0]        fill_r;
  logic [CNT_W-1:0]        fill_nxt;
  logic signed [SUM_W-1:0] sum_r [3];
  logic signed [SUM_W-1:0] sum_nxt [3];
  logic signed [SMP_W-1:0] in_ax [3];
  logic signed [SMP_W-1:0] old_ax [3];
  logic                    full;
  logic                    in_acc;
  logic                    v0_r;
  logic [DIV_ST-1:0]       dv_r;
  logic [DIV_ST-1:0]       en_d;
  logic                    en_acc;
  logic                    en_out;
  logic [TIME_W-1:0]       tp_r [DIV_ST];
  div_res_t                res [3];
  logic                    out_valid_r;
  logic [TIME_W-1:0]       out_time_r;
  logic signed [SMP_W-1:0] mean_r [3];

  assign in_ax[0]  = in_sample_x;
  assign in_ax[1]  = in_sample_y;
  assign in_ax[2]  = in_sample_z;
  assign old_ax[0] = vel_r[WINDOW-1].x;
  assign old_ax[1] = vel_r[WINDOW-1].y;
  assign old_ax[2] = vel_r[WINDOW-1].z;

  assign full = (fill_r == CNT_W'(WINDOW));

  always_comb begin
    en_out = !out_valid_r || !out_stall;
    en_d[DIV_ST-1] = !dv_r[DIV_ST-1] || en_out;
    for (int k = DIV_ST - 2; k >= 0; k--) begin
      en_d[k] = !dv_r[k] || en_d[k+1];
    end
    en_acc = !v0_r || en_d[0];
  end

  assign in_stall = !en_acc;
  assign in_acc   = in_valid && en_acc;
  assign fill_nxt = full ? fill_r : fill_r + 1'b1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_nxt[a] = sum_r[a] + SUM_W'(in_ax[a]) - (full ? SUM_W'(old_ax[a]) : '0);
    end
  end

  // advance the window shift line and centre-time taps
  always_ff @(posedge clk) begin
    if (in_acc) begin
      vel_r[0] <= '{x: in_sample_x, y: in_sample_y, z: in_sample_z};
      for (int k = 1; k < WINDOW; k++) begin
        vel_r[k] <= vel_r[k-1];
      end
      t_r[0] <= in_sample_time;
      for (int k = 1; k <= CENTER; k++) begin
        t_r[k] <= t_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      v0_r        <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        sum_r[a] <= '0;
      end
    end else begin
      if (in_acc) begin
        fill_r <= fill_nxt;
        for (int a = 0; a < 3; a++) begin
          sum_r[a] <= sum_nxt[a];
        end
      end
      if (en_acc) begin
        v0_r <= in_acc && (fill_r >= CNT_W'(WINDOW - 1));
      end
      if (en_d[0]) begin
        dv_r[0] <= v0_r;
      end
      for (int k = 1; k < DIV_ST; k++) begin
        if (en_d[k]) begin
          dv_r[k] <= dv_r[k-1];
        end
      end
      if (en_out) begin
        out_valid_r <= dv_r[DIV_ST-1];
      end
    end
  end

  // carry the centre time alongside the divider stages
  always_ff @(posedge clk) begin
    if (en_d[0]) begin
      tp_r[0] <= t_r[CENTER];
    end
    for (int k = 1; k < DIV_ST; k++) begin
      if (en_d[k]) begin
        tp_r[k] <= tp_r[k-1];
      end
    end
    if (en_out) begin
      out_time_r <= tp_r[DIV_ST-1];
      for (int a = 0; a < 3; a++) begin
        mean_r[a] <= res[a].neg ? -res[a].quo : res[a].quo;
      end
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    cbvs_div u_div (
      .clk      (clk),
      .stage_en (en_d),
      .sum_in   (sum_r[a]),
      .res      (res[a])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_center_time = out_time_r;
  assign out_mean_x      = mean_r[0];
  assign out_mean_y      = mean_r[1];
  assign out_mean_z      = mean_r[2];

endmodule

### dv/cbvs_mean_checker.sv
// Scoreboard for the centred boxcar vector smoother. It rebuilds the window mean and
// the centre timestamp from accepted sample beats, and checks every result beat.
// Depends on cbvs_pkg for the window size and the field widths.
module cbvs_mean_checker import cbvs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [TIME_W-1:0]       in_sample_time,
  input  logic signed [SMP_W-1:0] in_sample_x,
  input  logic signed [SMP_W-1:0] in_sample_y,
  input  logic signed [SMP_W-1:0] in_sample_z,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [TIME_W-1:0]       out_center_time,
  input  logic signed [SMP_W-1:0] out_mean_x,
  input  logic signed [SMP_W-1:0] out_mean_y,
  input  logic signed [SMP_W-1:0] out_mean_z,
  output int                      fail_count,
  output int                      due_count,
  output int                      beats_checked
);

  typedef struct packed {
    logic [TIME_W-1:0]       stamp;
    logic signed [SMP_W-1:0] mx;
    logic signed [SMP_W-1:0] my;
    logic signed [SMP_W-1:0] mz;
  } mean_beat_t;

  localparam int PRINT_CAP = 64;

  vec_t                    window_vecs[$];
  logic [TIME_W-1:0]       window_stamps[$];
  logic signed [SUM_W-1:0] run_x = '0;
  logic signed [SUM_W-1:0] run_y = '0;
  logic signed [SUM_W-1:0] run_z = '0;
  mean_beat_t              mean_due[$];
  int                      mismatches = 0;
  int                      compared = 0;

  assign fail_count    = mismatches;
  assign beats_checked = compared;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] mean beat %0d: %s", $time, compared, what);
    end
    mismatches++;
  endtask

  task automatic take_sample(input logic [TIME_W-1:0] stamp, input vec_t smp);
    vec_t       gone;
    mean_beat_t mean;
    window_vecs.insert(window_vecs.size(), smp);
    window_stamps.insert(window_stamps.size(), stamp);
    run_x += smp.x;
    run_y += smp.y;
    run_z += smp.z;
    if (window_vecs.size() > WINDOW) begin
      gone = window_vecs.pop_front();
      window_stamps.delete(0);
      run_x -= gone.x;
      run_y -= gone.y;
      run_z -= gone.z;
    end
    if (window_vecs.size() == WINDOW) begin
      mean.stamp = window_stamps[WINDOW / 2];
      mean.mx    = SMP_W'(run_x / WINDOW);
      mean.my    = SMP_W'(run_y / WINDOW);
      mean.mz    = SMP_W'(run_z / WINDOW);
      mean_due.insert(mean_due.size(), mean);
    end
  endtask

  always @(posedge clk) begin
    mean_beat_t due;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        take_sample(in_sample_time, {in_sample_x, in_sample_y, in_sample_z});
      end
      if (out_valid && !out_stall) begin
        if (mean_due.size() == 0) begin
          report_mismatch($sformatf("result with none due, center_time %h", out_center_time));
        end else begin
          due = mean_due.pop_front();
          if (out_center_time !== due.stamp) begin
            report_mismatch($sformatf("center_time %h, want %h", out_center_time, due.stamp));
          end
          if (out_mean_x !== due.mx) begin
            report_mismatch($sformatf("mean_x %0d, want %0d", out_mean_x, due.mx));
          end
          if (out_mean_y !== due.my) begin
            report_mismatch($sformatf("mean_y %0d, want %0d", out_mean_y, due.my));
          end
          if (out_mean_z !== due.mz) begin
            report_mismatch($sformatf("mean_z %0d, want %0d", out_mean_z, due.mz));
          end
        end
        compared++;
      end
    end
    due_count <= mean_due.size();
  end

endmodule

### dv/testbench.sv
// Top of the smoother testbench: clock, reset, sample and stall generation, verdict.
// Instantiates centered_boxcar_vector_smoother beside cbvs_mean_checker; uses cbvs_pkg.
module testbench;
  import cbvs_pkg::*;

  localparam int RUN_LIMIT    = 200000;
  localparam int DRAIN_CYCLES = 32;
  localparam int PHASE_BEATS  = 460;
  localparam logic signed [SMP_W-1:0] VMAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] VMIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic [TIME_W-1:0]       STAMP_TOP = '1;

  typedef enum {SEG_WIDE, SEG_TOP, SEG_BOTTOM, SEG_NEAR_ZERO, SEG_SWING} seg_style_e;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TIME_W-1:0]       in_sample_time = '0;
  logic signed [SMP_W-1:0] in_sample_x = '0;
  logic signed [SMP_W-1:0] in_sample_y = '0;
  logic signed [SMP_W-1:0] in_sample_z = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [TIME_W-1:0]       out_center_time;
  logic signed [SMP_W-1:0] out_mean_x;
  logic signed [SMP_W-1:0] out_mean_y;
  logic signed [SMP_W-1:0] out_mean_z;

  int                fail_count;
  int                due_count;
  int                beats_checked;
  int                send_gap_pct = 0;
  int                stall_pct = 0;
  int                beats_sent = 0;
  int                cycles = 0;
  logic [TIME_W-1:0] last_stamp = '0;

  centered_boxcar_vector_smoother u_top (.*);

  cbvs_mean_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("centered_boxcar_vector_smoother verification failed");
      $finish;
    end
  end

  function automatic logic signed [SMP_W-1:0] axis_value(input seg_style_e style, input int k);
    case (style)
      SEG_TOP:       return VMAX;
      SEG_BOTTOM:    return VMIN;
      SEG_NEAR_ZERO: return SMP_W'($signed($urandom_range(40)) - 20);
      SEG_SWING:     return k[0] ? VMAX : VMIN;
      default:       return SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [TIME_W-1:0] stamp,
                             input logic signed [SMP_W-1:0] vx,
                             input logic signed [SMP_W-1:0] vy,
                             input logic signed [SMP_W-1:0] vz);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_time <= stamp;
    in_sample_x    <= vx;
    in_sample_y    <= vy;
    in_sample_z    <= vz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    last_stamp = stamp;
  endtask

  task automatic run_phase(input int gap_pct, input int hold_pct);
    seg_style_e        style;
    int                left;
    logic [TIME_W-1:0] stamp;
    send_gap_pct = gap_pct;
    stall_pct    = hold_pct;
    left         = 0;
    for (int n = 0; n < PHASE_BEATS; n++) begin
      if (left == 0) begin
        style = seg_style_e'($urandom_range(SEG_SWING));
        if (style == SEG_TOP || style == SEG_BOTTOM) begin
          left = $urandom_range(40, WINDOW);
        end else begin
          left = $urandom_range(48, 1);
        end
      end
      left--;
      stamp = $urandom_range(1) ? TIME_W'({$urandom, $urandom}) : last_stamp + 1'b1;
      send_sample(stamp, axis_value(style, n), axis_value(style, n + 1), axis_value(style, n));
    end
  endtask

  initial begin
    logic [TIME_W-1:0] stamp;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 24; i++) begin
      stamp = (i == 0) ? '0 : (i == 1) ? STAMP_TOP : TIME_W'(i * 1000);
      case (i % 6)
        0:       send_sample(stamp, VMAX, VMIN, '0);
        1:       send_sample(stamp, VMIN, VMAX, -1);
        2:       send_sample(stamp, -1, 1, VMIN);
        3:       send_sample(stamp, 1, -1, VMAX);
        4:       send_sample(stamp, VMAX, VMAX, VMAX);
        default: send_sample(stamp, VMIN, VMIN, VMIN);
      endcase
    end
    run_phase(34, 81);
    run_phase(81, 34);
    run_phase(0, 0);
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d sample beats: extreme values, then random segments", beats_sent);
    $display("under three idle/stall mixes; %0d mean beats were compared.", beats_checked);
    if (fail_count == 0) begin
      $display("centered_boxcar_vector_smoother verification clean");
    end else begin
      $display("centered_boxcar_vector_smoother verification failed");
    end
    $finish;
  end

endmodule
